@@ sv/rgbhsi_pkg.sv @@
// ----------------------------------------------------------------------------
// RGB to HSI package
// Pixel and result types, CORDIC constants and the arctangent table.
// ----------------------------------------------------------------------------
package rgbhsi_pkg;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } pixel_t;

    typedef struct packed {
        logic [8:0] hue_deg;
        logic [6:0] sat_pct;
        logic [7:0] inten;
    } hsi_t;

    localparam int CORDIC_STEPS = 16;
    localparam int VEC_W        = 30;   // |x|,|y| < 2^28 over the whole run
    localparam int ANG_W        = 26;   // signed Q16 degrees, |z| < 2^25

    localparam logic [17:0] SQRT3_Q16 = 18'd113512;
    localparam logic signed [ANG_W-1:0] DEG90_Q16  = ANG_W'(90 * 65536);
    localparam logic signed [ANG_W-1:0] DEG180_Q16 = ANG_W'(180 * 65536);
    localparam logic [ANG_W-1:0]        DEG360_Q16 = ANG_W'(360 * 65536);

    typedef logic signed [VEC_W-1:0] vec_t;
    typedef logic signed [ANG_W-1:0] ang_t;

    typedef struct packed {
        vec_t x;
        vec_t y;
        ang_t z;
    } cordic_t;

    // Side-band carried alongside the vector through the pipeline.
    typedef struct packed {
        logic       hue_zero;   // gray or low saturation
        logic       b_gt_g;
        logic [6:0] sat_pct;
        logic [7:0] inten;
    } side_t;

    function automatic ang_t atan_q16(input logic [3:0] i);
        ang_t a;
        case (i)
            4'd0:  a = ANG_W'(2949120);
            4'd1:  a = ANG_W'(1740967);
            4'd2:  a = ANG_W'(919879);
            4'd3:  a = ANG_W'(466945);
            4'd4:  a = ANG_W'(234379);
            4'd5:  a = ANG_W'(117304);
            4'd6:  a = ANG_W'(58666);
            4'd7:  a = ANG_W'(29335);
            4'd8:  a = ANG_W'(14668);
            4'd9:  a = ANG_W'(7334);
            4'd10: a = ANG_W'(3667);
            4'd11: a = ANG_W'(1833);
            4'd12: a = ANG_W'(917);
            4'd13: a = ANG_W'(458);
            4'd14: a = ANG_W'(229);
            default: a = ANG_W'(115);
        endcase
        return a;
    endfunction

    // Arithmetic shift rounding toward zero (shift of the magnitude).
    function automatic vec_t shr_mag(input vec_t v, input logic [3:0] s);
        vec_t m;
        m = v[VEC_W-1] ? -v : v;
        m = m >>> s;
        return v[VEC_W-1] ? -m : m;
    endfunction

endpackage

@@ sv/rgb_to_hsi_converter_top.sv @@
// ----------------------------------------------------------------------------
// RGB to HSI converter, top level
// Stages: four front-end stages, eight CORDIC stages and the output register.
// Throughput: one pixel per cycle while the output is not stalled; each stage holds one pixel, 13 stages.
// The output register is the last stage; the whole pipe advances when it is
// empty or its result is taken, so a stall loses and repeats nothing.
// Reset (aresetn, synchronous, active low) clears every valid bit only.
// ----------------------------------------------------------------------------
module rgb_to_hsi_converter_top
    import rgbhsi_pkg::*;
(
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   s_valid,
    output logic   s_ready,
    input  pixel_t s_data,
    output logic   m_valid,
    input  logic   m_ready,
    output hsi_t   m_data
);

    logic    en;
    logic    f_valid, c_valid;
    cordic_t f_vec, c_vec;
    side_t   f_side, c_side;
    logic    out_v_reg;
    hsi_t    out_reg;
    ang_t    th;
    logic [ANG_W-1:0] wrap;
    logic [8:0] hue;

    // advance the whole pipe when the output slot is free or being drained
    assign en      = !out_v_reg || m_ready;
    assign s_ready = en;

    rgbhsi_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (s_valid),
        .in_pix   (s_data),
        .out_valid(f_valid),
        .out_vec  (f_vec),
        .out_side (f_side)
    );

    rgbhsi_cordic u_cordic (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (f_valid),
        .in_vec   (f_vec),
        .in_side  (f_side),
        .out_valid(c_valid),
        .out_vec  (c_vec),
        .out_side (c_side)
    );

    // saturate theta to [0,180] and fold for blue above green; hue is zero when hue_zero is set
    always_comb begin
        th = c_vec.z;
        if (th < 0) th = '0;
        if (th > DEG180_Q16) th = DEG180_Q16;
        wrap = DEG360_Q16 - ANG_W'(th);
        if (c_side.hue_zero) begin
            hue = '0;
        end else if (!c_side.b_gt_g) begin
            hue = 9'(th >>> 16);
        end else begin
            hue = (wrap[ANG_W-1:16] > 10'd359) ? 9'd359 : 9'(wrap[ANG_W-1:16]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_v_reg <= 1'b0;
        end else if (en) begin
            out_v_reg <= c_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            out_reg.hue_deg <= hue;
            out_reg.sat_pct <= c_side.sat_pct;
            out_reg.inten   <= c_side.inten;
        end
    end

    assign m_valid = out_v_reg;
    assign m_data  = out_reg;

    // a held result must not change while it waits
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_data))
        else $error("result changed while stalled");

    // input is refused only while a result waits
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid && !m_ready)
        else $error("input refused without back-pressure");

    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.hue_deg <= 9'd359 && m_data.sat_pct <= 7'd100)
        else $error("result out of range");

endmodule

@@ sv/rgbhsi_front.sv @@
// ----------------------------------------------------------------------------
// RGB to HSI front end
// Sum, min/max, saturation and the CORDIC start vector over four stages.
// ----------------------------------------------------------------------------
module rgbhsi_front
    import rgbhsi_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    en,
    input  logic    in_valid,
    input  pixel_t  in_pix,
    output logic    out_valid,
    output cordic_t out_vec,
    output side_t   out_side
);

    // stage 1: sum, min, max, differences
    logic        v1_reg;
    logic [9:0]  sum1_reg;
    logic        gray1_reg, bgtg1_reg;
    logic [9:0]  diff1_reg;
    logic signed [9:0] x1_reg;
    logic [7:0]  gb1_reg;

    // stage 2: products
    logic        v2_reg;
    logic [9:0]  sum2_reg;
    logic        gray2_reg, bgtg2_reg;
    logic [16:0] d100_2_reg;
    logic signed [9:0] x2_reg;
    logic [25:0] y2_reg;
    logic [7:0]  inten2_reg;

    // stage 3: upper quotient bits and pre-rotation
    logic        v3_reg;
    logic [9:0]  sum3_reg;
    logic        gray3_reg, bgtg3_reg, hz3_reg;
    logic [2:0]  qhi3_reg;
    logic [16:0] rem3_reg;
    logic [7:0]  inten3_reg;
    cordic_t     vec3_reg;

    // stage 4: lower quotient bits
    logic        v4_reg;
    cordic_t     vec4_reg;
    side_t       side4_reg;

    logic [7:0] r, g, b, mn, mx;
    logic [9:0] sum;
    logic [2:0] q_hi;
    logic [3:0] q_lo;
    logic [16:0] rem_hi, rem_lo;
    vec_t x0, y0;

    assign r = in_pix.red;
    assign g = in_pix.green;
    assign b = in_pix.blue;
    assign sum = 10'(r) + 10'(g) + 10'(b);

    always_comb begin
        mn = r;
        mx = r;
        if (g < mn) mn = g;
        if (b < mn) mn = b;
        if (g > mx) mx = g;
        if (b > mx) mx = b;
    end

    // quotient floor(d100/sum) <= 100: restoring division, bits 6..4 here
    always_comb begin
        rem_hi = d100_2_reg;
        q_hi = '0;
        for (int k = 6; k >= 4; k--) begin
            if ((rem_hi >> k) >= 17'(sum2_reg)) begin
                rem_hi = rem_hi - (17'(sum2_reg) << k);
                q_hi[k-4] = 1'b1;
            end
        end
    end

    // remaining quotient bits 3..0
    always_comb begin
        rem_lo = rem3_reg;
        q_lo = '0;
        for (int k = 3; k >= 0; k--) begin
            if ((rem_lo >> k) >= 17'(sum3_reg)) begin
                rem_lo = rem_lo - (17'(sum3_reg) << k);
                q_lo[k] = 1'b1;
            end
        end
    end

    always_comb begin
        x0 = VEC_W'(x2_reg) <<< 16;
        y0 = VEC_W'(y2_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sum1_reg  <= sum;
            gray1_reg <= (mx == mn);
            bgtg1_reg <= (b > g);
            diff1_reg <= sum - 10'(3 * 10'(mn));
            x1_reg    <= 10'(signed'({2'b0, r, 1'b0})) - 10'(g) - 10'(b);
            gb1_reg   <= (g >= b) ? g - b : b - g;

            sum2_reg   <= sum1_reg;
            gray2_reg  <= gray1_reg;
            bgtg2_reg  <= bgtg1_reg;
            d100_2_reg <= 17'(diff1_reg) * 17'd100;
            x2_reg     <= x1_reg;
            y2_reg     <= 26'(gb1_reg) * 26'(SQRT3_Q16);
            // floor(sum/3) as sum*683 >> 11, exact for sum <= 765
            inten2_reg <= 8'((20'(sum1_reg) * 20'd683) >> 11);

            sum3_reg   <= sum2_reg;
            gray3_reg  <= gray2_reg;
            bgtg3_reg  <= bgtg2_reg;
            hz3_reg    <= gray2_reg || (d100_2_reg <= 17'(sum2_reg));
            qhi3_reg   <= q_hi;
            rem3_reg   <= rem_hi;
            inten3_reg <= inten2_reg;
            if (x0 < 0) begin
                vec3_reg.x <= y0;
                vec3_reg.y <= -x0;
                vec3_reg.z <= DEG90_Q16;
            end else begin
                vec3_reg.x <= x0;
                vec3_reg.y <= y0;
                vec3_reg.z <= '0;
            end

            side4_reg.hue_zero <= hz3_reg;
            side4_reg.b_gt_g   <= bgtg3_reg;
            side4_reg.sat_pct  <= gray3_reg ? 7'd0 : {qhi3_reg, q_lo};
            side4_reg.inten    <= inten3_reg;
            vec4_reg           <= vec3_reg;
        end
    end

    assign out_valid = v4_reg;
    assign out_vec   = vec4_reg;
    assign out_side  = side4_reg;

endmodule

@@ sv/rgbhsi_cordic.sv @@
// ----------------------------------------------------------------------------
// RGB to HSI CORDIC pipeline
// Sixteen vectoring iterations, two per register stage.
// ----------------------------------------------------------------------------
module rgbhsi_cordic
    import rgbhsi_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    en,
    input  logic    in_valid,
    input  cordic_t in_vec,
    input  side_t   in_side,
    output logic    out_valid,
    output cordic_t out_vec,
    output side_t   out_side
);

    localparam int NSTG = CORDIC_STEPS / 2;

    logic    v_reg    [NSTG];
    cordic_t vec_reg  [NSTG];
    side_t   side_reg [NSTG];

    function automatic cordic_t iter(input cordic_t c, input logic [3:0] i);
        cordic_t o;
        vec_t xs, ys;
        xs = shr_mag(c.x, i);
        ys = shr_mag(c.y, i);
        if (c.y > 0) begin
            o.x = c.x + ys;
            o.y = c.y - xs;
            o.z = c.z + atan_q16(i);
        end else begin
            o.x = c.x - ys;
            o.y = c.y + xs;
            o.z = c.z - atan_q16(i);
        end
        return o;
    endfunction

    for (genvar s = 0; s < NSTG; s++) begin : g_stage
        cordic_t src;
        logic    src_v;
        side_t   src_side;
        if (s == 0) begin : g_first
            assign src = in_vec;
            assign src_v = in_valid;
            assign src_side = in_side;
        end else begin : g_next
            assign src = vec_reg[s-1];
            assign src_v = v_reg[s-1];
            assign src_side = side_reg[s-1];
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[s] <= 1'b0;
            end else if (en) begin
                v_reg[s] <= src_v;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                vec_reg[s]  <= iter(iter(src, 4'(2*s)), 4'(2*s+1));
                side_reg[s] <= src_side;
            end
        end
    end

    assign out_valid = v_reg[NSTG-1];
    assign out_vec   = vec_reg[NSTG-1];
    assign out_side  = side_reg[NSTG-1];

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// RGB to HSI converter testbench
// Drives directed and random pixels through the valid/ready input channel,
// predicts hue, saturation and intensity (or takes them from the directed table) for each transfer and checks every
// result transfer in order, with random idling on both channels.
// ----------------------------------------------------------------------------
module testbench;
    import rgbhsi_pkg::*;

    localparam int LATENCY     = 13;
    localparam int N_RANDOM    = 850;
    localparam int QUIET_START = 750;     // no idling from this item on
    localparam int STALL_LIMIT = 2000;

    typedef struct {
        pixel_t pix;
        logic   has_exp;
        hsi_t   exp_hsi;
    } stim_row_t;

    logic   aclk;
    logic   aresetn;
    logic   s_valid;
    logic   s_ready;
    pixel_t s_data;
    logic   m_valid;
    logic   m_ready;
    hsi_t   m_data;

    hsi_t      hsi_expected_q[$];
    stim_row_t pixel_table[$];
    int        mismatch_count = 0;
    int        pixels_sent;
    int        idle_cycles;
    bit        quiet_phase;
    bit        stim_done;

    rgb_to_hsi_converter_top uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Vectoring CORDIC on the angle of (x, y), degrees Q16, held to [0, 180]
    function automatic longint hue_angle_q16(input longint x0, input longint y0);
        longint x, y, z, xs, ys, t;
        longint atan_lut[16];
        atan_lut = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666,
                     29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115};
        x = x0;
        y = y0;
        z = 0;
        if (x < 0) begin
            t = x;
            x = y;
            y = -t;
            z = 90 * 65536;
        end
        for (int i = 0; i < 16; i++) begin
            xs = (x >= 0) ? (x >>> i) : -((-x) >>> i);
            ys = (y >= 0) ? (y >>> i) : -((-y) >>> i);
            if (y > 0) begin
                x = x + ys;
                y = y - xs;
                z = z + atan_lut[i];
            end else begin
                x = x - ys;
                y = y + xs;
                z = z - atan_lut[i];
            end
        end
        if (z < 0) z = 0;
        if (z > 180 * 65536) z = 180 * 65536;
        return z;
    endfunction

    function automatic hsi_t predict_hsi(input pixel_t p);
        hsi_t   h;
        int     r, g, b, mn, mx, sum, diff, hue;
        longint th;
        r   = p.red;
        g   = p.green;
        b   = p.blue;
        mn  = r < g ? (r < b ? r : b) : (g < b ? g : b);
        mx  = r > g ? (r > b ? r : b) : (g > b ? g : b);
        sum = r + g + b;
        h   = '0;
        h.inten = 8'(sum / 3);
        if (mx != mn) begin
            diff = sum - 3 * mn;
            h.sat_pct = 7'((100 * diff) / sum);
            if (100 * diff > sum) begin
                th = hue_angle_q16(longint'(2 * r - g - b) * 65536,
                                   longint'(g >= b ? g - b : b - g) * 113512);
                if (b <= g) begin
                    hue = int'(th >>> 16);
                end else begin
                    hue = int'((360 * 65536 - th) >>> 16);
                    if (hue > 359) hue = 359;
                end
                h.hue_deg = 9'(hue);
            end
        end
        return h;
    endfunction

    function automatic stim_row_t row(input int r, input int g, input int b,
                                      input logic has_exp = 1'b0,
                                      input int hue = 0, input int sat = 0,
                                      input int inten = 0);
        stim_row_t s;
        s.pix     = '{red: 8'(r), green: 8'(g), blue: 8'(b)};
        s.has_exp = has_exp;
        s.exp_hsi = '{hue_deg: 9'(hue), sat_pct: 7'(sat), inten: 8'(inten)};
        return s;
    endfunction

    // Send one pixel; hold valid and payload until the transfer
    task automatic send_pixel(input pixel_t p, input hsi_t exp_hsi);
        int gap;
        if (!quiet_phase && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 17);
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= p;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        hsi_expected_q.push_back(exp_hsi);
        pixels_sent++;
        @(negedge aclk);
    endtask

    // Directed table: gray, extremes, hue sectors, low saturation, the wrap
    initial begin
        pixel_table.push_back(row(0, 0, 0, 1'b1, 0, 0, 0));          // black
        pixel_table.push_back(row(255, 255, 255, 1'b1, 0, 0, 255));  // white
        pixel_table.push_back(row(128, 128, 128, 1'b1, 0, 0, 128));  // mid gray
        pixel_table.push_back(row(255, 0, 0, 1'b1, 0, 100, 85));     // pure red
        pixel_table.push_back(row(0, 255, 0));
        pixel_table.push_back(row(0, 0, 255));
        pixel_table.push_back(row(255, 255, 0));
        pixel_table.push_back(row(0, 255, 255));
        pixel_table.push_back(row(255, 0, 255));
        pixel_table.push_back(row(255, 0, 1));                        // hue wrap
        pixel_table.push_back(row(255, 1, 2));
        pixel_table.push_back(row(200, 100, 101));
        pixel_table.push_back(row(100, 100, 101));                    // low saturation
        pixel_table.push_back(row(255, 255, 254));
        pixel_table.push_back(row(1, 0, 0));
        pixel_table.push_back(row(0, 1, 0));
        pixel_table.push_back(row(0, 0, 1));
        pixel_table.push_back(row(170, 85, 85));
        pixel_table.push_back(row(85, 170, 255));
        pixel_table.push_back(row(254, 1, 127));
        pixel_table.push_back(row(17, 200, 3));
    end

    // Stimulus
    initial begin
        pixel_t p;
        hsi_t   e;
        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_data         = '0;
        pixels_sent    = 0;
        quiet_phase    = 1'b0;
        stim_done      = 1'b0;
        repeat (4) @(negedge aclk);
        aresetn = 1'b1;

        foreach (pixel_table[i]) begin
            e = pixel_table[i].has_exp ? pixel_table[i].exp_hsi
                                       : predict_hsi(pixel_table[i].pix);
            send_pixel(pixel_table[i].pix, e);
        end
        for (int n = 0; n < N_RANDOM; n++) begin
            if (n >= QUIET_START) quiet_phase = 1'b1;
            case ($urandom_range(0, 7))
                0: begin                                  // near gray
                    p.red   = 8'($urandom_range(0, 255));
                    p.green = p.red + 8'($urandom_range(0, 2));
                    p.blue  = p.red - 8'($urandom_range(0, 2));
                end
                1: begin                                  // saturated extremes
                    p.red   = $urandom_range(0, 1) ? 8'hff : 8'h00;
                    p.green = 8'($urandom_range(0, 255));
                    p.blue  = $urandom_range(0, 1) ? 8'hff : 8'h00;
                end
                default: p = pixel_t'(24'($urandom));
            endcase
            send_pixel(p, predict_hsi(p));
        end
        s_valid   <= 1'b0;
        stim_done = 1'b1;
    end

    // Result side: random back-pressure in bursts, none in the last part
    initial begin
        int gap;
        m_ready = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (!quiet_phase && $urandom_range(0, 5) == 0) begin
                gap = $urandom_range(1, 17);
                m_ready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_ready <= 1'b1;
        end
    end

    // Check each result transfer against the oldest expectation
    always @(posedge aclk) begin
        hsi_t e;
        if (aresetn && m_valid && m_ready) begin
            if (hsi_expected_q.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result hue=%0d sat=%0d int=%0d",
                             m_data.hue_deg, m_data.sat_pct, m_data.inten);
            end else begin
                e = hsi_expected_q.pop_front();
                if (m_data !== e) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: exp hue=%0d sat=%0d int=%0d, got hue=%0d sat=%0d int=%0d",
                                 e.hue_deg, e.sat_pct, e.inten,
                                 m_data.hue_deg, m_data.sat_pct, m_data.inten);
                end
            end
        end
    end

    // Watchdog: count cycles with no transfer on either channel
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // End of run: drain, then allow the pipeline latency for stray results
    initial begin
        wait (stim_done);
        while (hsi_expected_q.size() != 0) @(posedge aclk);
        repeat (LATENCY * 2) @(posedge aclk);
        if (mismatch_count == 0 && hsi_expected_q.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

@@ files.f @@
sv/rgbhsi_pkg.sv
sv/rgbhsi_front.sv
sv/rgbhsi_cordic.sv
sv/rgb_to_hsi_converter_top.sv
sim/testbench.sv
